### rtl/midi_uart_port_message_assembler_macros.svh
// Assertion helpers used by the top-level RTL module.
`ifndef MIDI_UART_PORT_MESSAGE_ASSEMBLER_MACROS_SVH
`define MIDI_UART_PORT_MESSAGE_ASSEMBLER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define MUPA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds after ante.
`define MUPA_ASSERT_LAT2(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

### rtl/mupa_pkg.sv
`default_nettype none

package mupa_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [15:0] IoBaseReset = 16'h0330;

  localparam logic [7:0] RealtimeMin = 8'hF8;
  localparam logic [7:0] SysexStart  = 8'hF0;
  localparam logic [7:0] SysexEnd    = 8'hF7;
  localparam logic [7:0] CmdReset    = 8'hFF;
  localparam logic [7:0] CmdUart     = 8'h3F;
  localparam logic [7:0] AckByte     = 8'hFE;
  localparam logic [7:0] EmptyRead   = 8'hFF;
  localparam logic [7:0] StatusEmpty = 8'h80;
  localparam logic [7:0] StatusReady = 8'h00;
  localparam logic [3:0] HiProgram   = 4'hC;
  localparam logic [3:0] HiPressure  = 4'hD;
  localparam logic [3:0] HiNoteOff   = 4'h8;
  localparam logic [3:0] HiPitch     = 4'hE;
  localparam logic [7:0] TimeCode    = 8'hF1;
  localparam logic [7:0] SongSelect  = 8'hF3;
  localparam logic [7:0] SongPos     = 8'hF2;

  localparam logic OpcodeRead = 1'b0;

  typedef enum logic [3:0] {
    OP_RD_DATA,
    OP_RD_STATUS,
    OP_MIDI_RT,
    OP_MIDI_SOX,
    OP_MIDI_EOX,
    OP_MIDI_STATUS,
    OP_MIDI_DATA,
    OP_CMD_RESET,
    OP_CMD_UART,
    OP_CMD_OTHER
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [1:0] wanted;
  } fe_entry_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       msg_valid;
    logic [7:0] msg_status;
    logic [6:0] msg_data_first;
    logic [6:0] msg_data_second;
  } result_t;

  // Number of data bytes that follow a status byte.
  function automatic logic [1:0] wanted_for(input logic [7:0] s);
    logic [1:0] w;
    w = 2'd0;
    if (s[7:4] == HiProgram || s[7:4] == HiPressure) begin
      w = 2'd1;
    end else if (s[7:4] >= HiNoteOff && s[7:4] <= HiPitch) begin
      w = 2'd2;
    end else if (s == TimeCode || s == SongSelect) begin
      w = 2'd1;
    end else if (s == SongPos) begin
      w = 2'd2;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/mupa_front.sv
`default_nettype none

module mupa_front import mupa_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic        opcode_i,
  input  wire logic [15:0] io_port_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [15:0] io_base_i,
  output logic             ent_valid_o,
  output fe_entry_t        ent_o,
  input  wire logic        ent_take_i
);

  fe_entry_t  slot_q [2];
  logic       rd_ptr_q, wr_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  fe_entry_t  cls;
  logic       do_push, do_pop, is_data_port;

  // Classify the access.
  always_comb begin
    is_data_port = (io_port_i == io_base_i);
    cls.data     = write_data_i;
    cls.wanted   = wanted_for(write_data_i);
    if (opcode_i == OpcodeRead) begin
      cls.op = is_data_port ? OP_RD_DATA : OP_RD_STATUS;
    end else if (!is_data_port) begin
      if (write_data_i == CmdReset) begin
        cls.op = OP_CMD_RESET;
      end else if (write_data_i == CmdUart) begin
        cls.op = OP_CMD_UART;
      end else begin
        cls.op = OP_CMD_OTHER;
      end
    end else if (write_data_i >= RealtimeMin) begin
      cls.op = OP_MIDI_RT;
    end else if (write_data_i == SysexStart) begin
      cls.op = OP_MIDI_SOX;
    end else if (write_data_i == SysexEnd) begin
      cls.op = OP_MIDI_EOX;
    end else if (write_data_i[7]) begin
      cls.op = OP_MIDI_STATUS;
    end else begin
      cls.op = OP_MIDI_DATA;
    end
  end

  assign full_o      = (cnt_q == 2'd2);
  assign ent_valid_o = (cnt_q != 2'd0);
  assign ent_o       = slot_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = ent_take_i && ent_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

### rtl/mupa_back.sv
`default_nettype none

module mupa_back import mupa_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      ent_valid_i,
  input  wire fe_entry_t ent_i,
  output logic           ent_take_o,
  output logic           empty_o,
  input  wire logic      pop_i,
  output result_t        res_o
);

  logic             uart_q, uart_d;
  logic [7:0]       rs_q, rs_d;
  logic [6:0]       db0_q, db0_d, db1_q, db1_d;
  logic [1:0]       dcnt_q, dcnt_d;
  logic [1:0]       dwant_q, dwant_d;
  logic             sysex_q, sysex_d;
  logic [QCntW-1:0] qcnt_q, qcnt_d;
  logic             ack;
  logic [2:0]       dcnt_inc;
  result_t          res;

  result_t          oslot_q [2];
  logic             ord_q, owr_q;
  logic [1:0]       ocnt_q, ocnt_d;
  logic             do_opop;

  assign ent_take_o = ent_valid_i && (ocnt_q != 2'd2);
  assign dcnt_inc   = {1'b0, dcnt_q} + 3'd1;

  always_comb begin
    uart_d  = uart_q;
    rs_d    = rs_q;
    db0_d   = db0_q;
    db1_d   = db1_q;
    dcnt_d  = dcnt_q;
    dwant_d = dwant_q;
    sysex_d = sysex_q;
    qcnt_d  = qcnt_q;
    ack     = 1'b0;
    res     = '0;
    if (ent_take_o) begin
      case (ent_i.op)
        OP_RD_DATA: begin
          if (qcnt_q != '0) begin
            res.read_data = AckByte;
            qcnt_d        = qcnt_q - QCntW'(1);
          end else begin
            res.read_data = EmptyRead;
          end
        end
        OP_RD_STATUS: begin
          res.read_data = (qcnt_q != '0) ? StatusReady : StatusEmpty;
        end
        OP_CMD_RESET: begin
          uart_d  = 1'b0;
          rs_d    = '0;
          dcnt_d  = '0;
          sysex_d = 1'b0;
          ack     = 1'b1;
        end
        OP_CMD_UART: begin
          uart_d = 1'b1;
          ack    = 1'b1;
        end
        OP_CMD_OTHER: begin
          ack = 1'b1;
        end
        OP_MIDI_RT: begin
          if (uart_q) begin
            res.msg_valid  = 1'b1;
            res.msg_status = ent_i.data;
          end
        end
        OP_MIDI_SOX: begin
          if (uart_q) begin
            sysex_d = 1'b1;
          end
        end
        OP_MIDI_EOX: begin
          if (uart_q) begin
            sysex_d = 1'b0;
          end
        end
        OP_MIDI_STATUS: begin
          if (uart_q && !sysex_q) begin
            rs_d    = ent_i.data;
            dcnt_d  = '0;
            dwant_d = ent_i.wanted;
            if (ent_i.wanted == 2'd0) begin
              db0_d          = '0;
              db1_d          = '0;
              res.msg_valid  = 1'b1;
              res.msg_status = ent_i.data;
            end
          end
        end
        OP_MIDI_DATA: begin
          // Collect a data byte under running status; drop it outside UART mode, inside SysEx, or if no status yet.
          if (uart_q && !sysex_q && rs_q != '0) begin
            if (dcnt_q == 2'd0) begin
              db0_d = ent_i.data[6:0];
            end else if (dcnt_q == 2'd1) begin
              db1_d = ent_i.data[6:0];
            end
            dcnt_d = dcnt_inc[1:0];
            if (dcnt_inc >= {1'b0, dwant_q}) begin
              if (dwant_q < 2'd2) begin
                db1_d = '0;
              end
              res.msg_valid       = 1'b1;
              res.msg_status      = rs_q;
              res.msg_data_first  = db0_d;
              res.msg_data_second = db1_d;
              dcnt_d              = '0;
            end
          end
        end
        default: begin
          res = '0;
        end
      endcase
      if (ack && (qcnt_q < QCntW'(QueueDepth))) begin
        qcnt_d = qcnt_q + QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uart_q  <= 1'b0;
      rs_q    <= '0;
      db0_q   <= '0;
      db1_q   <= '0;
      dcnt_q  <= '0;
      dwant_q <= '0;
      sysex_q <= 1'b0;
      qcnt_q  <= '0;
    end else begin
      uart_q  <= uart_d;
      rs_q    <= rs_d;
      db0_q   <= db0_d;
      db1_q   <= db1_d;
      dcnt_q  <= dcnt_d;
      dwant_q <= dwant_d;
      sysex_q <= sysex_d;
      qcnt_q  <= qcnt_d;
    end
  end

  // Result queue.
  assign empty_o = (ocnt_q == 2'd0);
  assign do_opop = pop_i && !empty_o;
  assign res_o   = oslot_q[ord_q];

  always_comb begin
    ocnt_d = ocnt_q;
    if (ent_take_o && !do_opop) begin
      ocnt_d = ocnt_q + 2'd1;
    end else if (!ent_take_o && do_opop) begin
      ocnt_d = ocnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ord_q  <= 1'b0;
      owr_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      ocnt_q <= ocnt_d;
      if (ent_take_o) begin
        owr_q <= !owr_q;
      end
      if (do_opop) begin
        ord_q <= !ord_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_take_o) begin
      oslot_q[owr_q] <= res;
    end
  end

endmodule

`default_nettype wire

### rtl/midi_uart_port_message_assembler.sv
// MIDI interface port in UART mode. Each bus access (read or write, port, byte) pushed
// into the input queue yields exactly one result, popped in order from the result queue.
// Throughput is one access per cycle while neither queue is full. A pushed access passes
// the front (decode of the port against io_base and classification of the byte), then the
// back (MIDI parser and reply-count update), each followed by a two-entry queue so either
// side may stall alone.
// Every byte the reply queue holds is the acknowledge 0xFE, so the back keeps the fill
// count only (QueueDepth entries, overflow dropped); a data-port read gives 0xFE while the
// count is nonzero and 0xFF otherwise. io_base is written through the cfg channel, which
// is always ready; write it only while the block is idle.

`default_nettype none

module midi_uart_port_message_assembler import mupa_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        opcode_i,
  input  wire logic [15:0] io_port_i,
  input  wire logic [7:0]  write_data_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       read_data_o,
  output logic             msg_valid_o,
  output logic [7:0]       msg_status_o,
  output logic [6:0]       msg_data_first_o,
  output logic [6:0]       msg_data_second_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

`include "midi_uart_port_message_assembler_macros.svh"

  logic [15:0] io_base_q;
  logic        ent_valid, ent_take;
  fe_entry_t   ent;
  result_t     res;

  // Configuration: one register, taken on any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      io_base_q <= IoBaseReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      io_base_q <= cfg_data_i;
    end
  end

  // Front: decode and classify each transaction, hold it in a short queue.
  mupa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .opcode_i     (opcode_i),
    .io_port_i    (io_port_i),
    .write_data_i (write_data_i),
    .io_base_i    (io_base_q),
    .ent_valid_o  (ent_valid),
    .ent_o        (ent),
    .ent_take_i   (ent_take)
  );

  // Back: advance parser and reply count, queue the result.
  mupa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (ent_valid),
    .ent_i       (ent),
    .ent_take_o  (ent_take),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign read_data_o       = res.read_data;
  assign msg_valid_o       = res.msg_valid;
  assign msg_status_o      = res.msg_status;
  assign msg_data_first_o  = res.msg_data_first;
  assign msg_data_second_o = res.msg_data_second;

  // A message result never carries read data, and its status byte has the top bit set.
  `MUPA_ASSERT_IMPL(a_msg_no_read, !empty && msg_valid_o, read_data_o == 8'h00 && msg_status_o[7], "message result with read data or bad status")
  // Without a message, the message fields stay zero.
  `MUPA_ASSERT_IMPL(a_nomsg_zero, !empty && !msg_valid_o, msg_status_o == 8'h00 && msg_data_first_o == 7'h00 && msg_data_second_o == 7'h00, "message fields set without a message")
  // Into an idle block, a transaction shows its result once registered into the front queue and then the result queue.
  `MUPA_ASSERT_LAT2(a_latency, push && !full && !ent_valid && empty, !empty, "result missing two cycles after push into idle block")

endmodule

`default_nettype wire
